>>> rtl/isa_pkg.sv
package isa_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } isa_ctl_t;

endpackage

>>> rtl/integer_array_sort.sv
// channel | handshake            | fields                                         | role
// in      | in_valid, in_ready   | in_value, in_last_in                           | item in
// out     | out_valid, out_ready | out_sorted_value, out_last_out, out_overflowed | item out
//
// Loading: one item per cycle; each cell compares with the new item in parallel
// and takes its left neighbor's value or the item, so an item is in place after the next clock edge.
// After the last item, the stored results stream out of cell 0, one per cycle while
// out_ready is high, as the chain shifts left; in_ready is low until the final result is taken.
// Synchronous active-low reset empties the run and clears the overflow mark.
// out_ready low simply holds the chain; no result is lost.
module integer_array_sort import isa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  data_t       in_value,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_ready,
  output data_t       out_sorted_value,
  output logic        out_last_out,
  output logic        out_overflowed
);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic     state_r, state_nxt;
  cnt_t     count_r, count_nxt;
  logic     ovf_r, ovf_nxt;
  logic     in_acc, out_acc, full;
  isa_ctl_t ctl;

  data_t vals [CAPACITY];
  logic  gts  [CAPACITY];

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = (state_r == ST_EMIT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign full      = (count_r == cnt_t'(CAPACITY));

  assign ctl.ins   = in_acc && !full;
  assign ctl.shift = out_acc;

  assign out_sorted_value = vals[0];
  assign out_last_out     = (count_r == cnt_t'(1));
  assign out_overflowed   = ovf_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    data_t pv, nv;
    logic  pg;
    if (i == 0) begin : g_first
      assign pv = in_value;
      assign pg = 1'b0;
    end else begin : g_mid
      assign pv = vals[i-1];
      assign pg = gts[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign nv = vals[i];
    end else begin : g_body
      assign nv = vals[i+1];
    end
    isa_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occ      (count_r > cnt_t'(i)),
      .in_val   (in_value),
      .prev_val (pv),
      .prev_gt  (pg),
      .next_val (nv),
      .val      (vals[i]),
      .gt       (gts[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + cnt_t'(1);
          end
          if (in_last_in) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          count_nxt = count_r - cnt_t'(1);
          if (out_last_out) begin
            state_nxt = ST_LOAD;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("load and emit overlap");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (count_r != '0)) else $error("emitting from empty run");

  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_out) |=> (!out_valid && count_r == '0 && !ovf_r))
    else $error("state not cleared after final item");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(CAPACITY)) else $error("count beyond capacity");

endmodule

>>> rtl/isa_cell.sv
module isa_cell import isa_pkg::*; (
  input  logic     clk,
  input  isa_ctl_t ctl,
  input  logic     occ,
  input  data_t    in_val,
  input  data_t    prev_val,
  input  logic     prev_gt,
  input  data_t    next_val,
  output data_t    val,
  output logic     gt
);

  data_t val_r;
  data_t val_nxt;

  assign val = val_r;
  assign gt  = occ && (val_r > in_val);

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins) begin
      if (gt || !occ) begin
        val_nxt = prev_gt ? prev_val : in_val;
      end
    end else if (ctl.shift) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import isa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_ITEMS = 500;
  localparam int LONG_HOLD = 400;

  localparam data_t VAL_MIN = 32'sh8000_0000;
  localparam data_t VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    data_t       value;
    logic        is_last;
    int unsigned gap;
    bit          drain;
  } sort_item_t;

  typedef struct {
    data_t value;
    logic  is_last;
    logic  ovf;
  } sort_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  data_t in_value = '0;
  logic in_last_in = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  data_t out_sorted_value;
  logic out_last_out;
  logic out_overflowed;

  sort_item_t   pending[$];
  data_t        run_vals[$];
  bit           run_dropped;
  sort_result_t sorted_due[$];

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned cycle_count;
  int unsigned item_total;
  int unsigned gap_left;
  int unsigned hold_left;
  int unsigned rdy_left;
  int unsigned stall_left;
  bit          held_once;

  integer_array_sort DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value        (in_value),
    .in_last_in      (in_last_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sorted_value(out_sorted_value),
    .out_last_out    (out_last_out),
    .out_overflowed  (out_overflowed)
  );

  always #5 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  function automatic data_t pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    case (r % 5)
      0: if (r < 10) return VAL_MIN;
      1: if (r < 10) return VAL_MAX;
      2: if (r < 10) return '0;
      3: if (r < 10) return -1;
      default: if (r < 10) return 1;
    endcase
    if (r < 30) return data_t'($urandom_range(0, 7)) - 4;
    return data_t'($urandom);
  endfunction

  function automatic void add_item(data_t v, logic is_last, int unsigned gap, bit drain);
    pending.push_back('{v, is_last, gap, drain});
    item_total++;
  endfunction

  function automatic void add_array(int unsigned len, bit burst);
    for (int unsigned i = 0; i < len; i++) begin
      add_item(pick_value(), i == len - 1, burst ? 0 : pick_gap(),
               i == 0 && $urandom_range(0, 5) == 0);
    end
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(1, 6);
    if (r < 75) return $urandom_range(7, CAPACITY - 1);
    if (r < 90) return $urandom_range(CAPACITY, CAPACITY + 2);
    return $urandom_range(CAPACITY + 3, CAPACITY + 16);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic take_item(input data_t v, input logic is_last);
    int pos;
    if (run_vals.size() < CAPACITY) begin
      pos = run_vals.size();
      while (pos > 0 && run_vals[pos - 1] > v) pos--;
      run_vals.insert(pos, v);
    end else begin
      run_dropped = 1'b1;
    end
    if (is_last) begin
      foreach (run_vals[k]) begin
        sorted_due.push_back('{run_vals[k], (k == run_vals.size() - 1) ? 1'b1 : 1'b0,
                               run_dropped});
      end
      run_vals.delete();
      run_dropped = 1'b0;
    end
  endtask

  task automatic check_result();
    sort_result_t exp;
    if (sorted_due.size() == 0) begin
      report_mismatch($sformatf("result %0d with none expected", out_sorted_value));
      return;
    end
    exp = sorted_due.pop_front();
    if (out_sorted_value !== exp.value)
      report_mismatch($sformatf("sorted_value %0d, expected %0d", out_sorted_value, exp.value));
    if (out_last_out !== exp.is_last)
      report_mismatch($sformatf("last_out %b, expected %b (value %0d)",
                                out_last_out, exp.is_last, exp.value));
    if (out_overflowed !== exp.ovf)
      report_mismatch($sformatf("overflowed %b, expected %b (value %0d)",
                                out_overflowed, exp.ovf, exp.value));
    results_seen++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending.size() != 0 &&
                   !(pending[0].drain &&
                     (sorted_due.size() != 0 || (in_valid && in_last_in)))) begin
        in_valid   <= 1'b1;
        in_value   <= pending[0].value;
        in_last_in <= pending[0].is_last;
        void'(pending.pop_front());
        if (pending.size() != 0) gap_left = pending[0].gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!held_once && out_valid === 1'b1 && results_seen >= 40) begin
      held_once = 1'b1;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (rdy_left > 0) begin
      rdy_left--;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      rdy_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300) : $urandom_range(1, 10);
      stall_left = pick_gap();
      out_ready <= 1'b1;
    end
  end

  // monitor: results are checked before the item taken at the same edge is predicted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_ready) check_result();
      if (in_valid && in_ready === 1'b1) take_item(in_value, in_last_in);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    // extremes, duplicates, single element
    add_item(VAL_MAX, 1'b0, 0, 1'b0);
    add_item(VAL_MIN, 1'b0, 0, 1'b0);
    add_item('0, 1'b0, 0, 1'b0);
    add_item(-1, 1'b0, 0, 1'b0);
    add_item(1, 1'b0, 0, 1'b0);
    add_item(VAL_MAX, 1'b0, 0, 1'b0);
    add_item(VAL_MIN, 1'b1, 0, 1'b0);
    add_item(VAL_MIN, 1'b1, 0, 1'b1);
    add_item(VAL_MAX, 1'b1, 2, 1'b0);
    add_item(3, 1'b0, 0, 1'b1);
    add_item(3, 1'b0, 1, 1'b0);
    add_item(-3, 1'b1, 0, 1'b0);
    // full run, one dropped, several dropped including the last
    add_array(CAPACITY, 1'b1);
    add_array(CAPACITY + 1, 1'b0);
    add_array(CAPACITY + 8, 1'b1);
    while (item_total < RANDOM_ITEMS) add_array(pick_len(), $urandom_range(0, 4) == 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (out_valid === 1'b1) report_mismatch("result after all expected results");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
